### src/sket_pkg.sv
// Shared types, codes and key-order function for the sorted key/entry table.
// No dependencies; every other file in src imports this package.
package sket_pkg;

    // Default number of cells in the chain
    localparam int DEPTH_DEF = 128;

    // Field widths
    localparam int KEY_W   = 64;
    localparam int PAGE_W  = 32;
    localparam int SLOT_W  = 32;
    localparam int RIDX_W  = 7;
    localparam int STAT_W  = 3;
    localparam int OCNT_W  = 8;
    localparam int POS_W   = 7;
    localparam int MODE_W  = 2;

    // Stream and configuration widths
    localparam int IN_DATA_W  = 136;
    localparam int IN_USER_W  = MODE_W;
    localparam int OUT_DATA_W = 144;
    localparam int OUT_USER_W = STAT_W;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    // Register reset values
    localparam logic [7:0] CAP_RESET = 8'd128;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_FLOAT = 8'd1;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_ERASE  = 2'd1,
        MODE_READ   = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_ERASED    = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4,
        ST_READ_OK   = 3'd5,
        ST_RANGE     = 3'd6,
        ST_CLEARED   = 3'd7
    } t_status;

    // One stored key with its entry
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [PAGE_W-1:0] page;
        logic [SLOT_W-1:0] slot;
    } t_entry;

    // Per-cell update command
    typedef struct packed {
        logic shift_up;    // take the entry of the cell below
        logic shift_down;  // take the entry of the cell above
        logic load_key;    // take the new key and entry
        logic load_entry;  // take the new page and slot, keep the key
    } t_cell_ctl;

    // Map a key to an unsigned code whose order is the key order
    function automatic logic [KEY_W-1:0] order_code(input logic [KEY_W-1:0] k,
                                                    input logic is_float);
        logic [KEY_W-1:0] v;
        v = k;
        if (is_float) begin
            if (k[KEY_W-2:0] == '0) begin
                v = '0;
            end
            if (v[KEY_W-1]) begin
                order_code = ~v;
            end else begin
                order_code = {~v[KEY_W-1], v[KEY_W-2:0]};
            end
        end else begin
            order_code = {~v[KEY_W-1], v[KEY_W-2:0]};
        end
    endfunction

endpackage

### src/sket_cell.sv
// One cell of the table chain: holds a key and its entry, compares against
// the broadcast search code and moves entries to and from its neighbors.
// Depends on sket_pkg.
module sket_cell (
    input  logic                  i_clk,
    input  logic                  i_cmp_en,
    input  logic                  i_is_float,
    input  logic [63:0]           i_cmp_code,
    input  sket_pkg::t_cell_ctl   i_ctl,
    input  sket_pkg::t_entry      i_new,
    input  sket_pkg::t_entry      i_lo,
    input  sket_pkg::t_entry      i_hi,
    output sket_pkg::t_entry      o_entry,
    output logic                  o_ge,
    output logic                  o_eq
);
    import sket_pkg::*;

    t_entry           r_entry;
    t_entry           n_entry;
    logic             r_ge;
    logic             r_eq;
    logic [KEY_W-1:0] w_code;

    assign w_code = order_code(r_entry.key, i_is_float);

    // Capture compare flags when a request enters
    always_ff @(posedge i_clk) begin
        if (i_cmp_en) begin
            r_ge <= (w_code >= i_cmp_code);
            r_eq <= (w_code == i_cmp_code);
        end
    end

    // Select the next entry: shift, load or hold
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.shift_up) begin
            n_entry = i_lo;
        end else if (i_ctl.shift_down) begin
            n_entry = i_hi;
        end else if (i_ctl.load_key) begin
            n_entry = i_new;
        end else if (i_ctl.load_entry) begin
            n_entry.page = i_new.page;
            n_entry.slot = i_new.slot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_ge    = r_ge;
    assign o_eq    = r_eq;

endmodule

### src/sket_find.sv
// Lowest-set-bit finder over the cell flags: one-hot hit, mask of cells at
// or below the hit, and the hit index. Depends on sket_pkg only by import.
module sket_find #(
    parameter int DEPTH = sket_pkg::DEPTH_DEF
) (
    input  logic [DEPTH-1:0]         i_vec,
    output logic [DEPTH-1:0]         o_hot,
    output logic [DEPTH-1:0]         o_le,
    output logic [$clog2(DEPTH)-1:0] o_idx,
    output logic                     o_any
);
    import sket_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);

    logic [DEPTH-1:0] w_dec;

    // Borrow ripples up to the lowest set bit
    assign w_dec = i_vec - DEPTH'(1);
    assign o_le  = i_vec ^ w_dec;
    assign o_hot = i_vec & ~w_dec;
    assign o_any = |i_vec;

    // Encode the one-hot hit
    always_comb begin
        o_idx = '0;
        for (int j = 0; j < DEPTH; j++) begin
            if (o_hot[j]) begin
                o_idx = o_idx | IDX_W'(j);
            end
        end
    end

endmodule

### src/sorted_key_entry_table_top.sv
// Top level of the sorted key/entry table: request and result streams,
// configuration port, cell chain and result register.
// Depends on sket_pkg, sket_cell and sket_find.
//
//  port group   dir  handshake              payload
//  i_s_axis_*   in   tvalid/tready          tuser mode, tdata key/page/slot/index
//  o_m_axis_*   out  tvalid/tready          tuser status, tdata count/pos/key/entry
//  i_cfg_*      in   i_cfg_valid/o_cfg_ready register index and data
//
// The cells compare their keys in the cycle a request is taken and register the
// flags; the work cycle then finds the hit, shifts the chain and loads the result
// register. One request is in work at a time.
// A result waiting in the output register does not block the next request;
// a second result stalls in the work cycle until the first one is taken.
// Reset (i_rst_n low, synchronous) empties the table and restores registers.
module sorted_key_entry_table_top #(
    parameter int TABLE_DEPTH = sket_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // tdata: search_key[63:0], page_number[95:64], slot_number[127:96],
    //        read_index[134:128], zero pad[135]
    input  logic [sket_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // tuser: mode[1:0]
    input  logic [sket_pkg::IN_USER_W-1:0]    i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // tdata: stored_count[7:0], position[14:8], key_out[78:15],
    //        page_out[110:79], slot_out[142:111], zero pad[143]
    output logic [sket_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    // tuser: status[2:0]
    output logic [sket_pkg::OUT_USER_W-1:0]   o_m_axis_tuser,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sket_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sket_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import sket_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
    localparam int RW    = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;
    localparam int PW    = (IDX_W > POS_W) ? IDX_W : POS_W;

    // Configuration registers
    logic [7:0]       r_cap;
    logic             r_float;

    // Request registers
    logic             r_busy;
    t_mode            r_mode;
    t_entry           r_req;
    logic [RIDX_W-1:0] r_ri;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // Result register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;

    logic             w_accept;
    logic             w_fire;
    logic [KEY_W-1:0] w_cmp_code;
    t_entry           w_in_entry;

    t_entry           w_entry [TABLE_DEPTH];
    t_cell_ctl        w_ctl   [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_ge;
    logic [TABLE_DEPTH-1:0] w_eq;
    logic [TABLE_DEPTH-1:0] w_valid;
    logic [TABLE_DEPTH-1:0] w_top;
    logic [TABLE_DEPTH-1:0] w_scan;
    logic [TABLE_DEPTH-1:0] w_hot;
    logic [TABLE_DEPTH-1:0] w_le;
    logic [IDX_W-1:0]       w_idx;
    logic                   w_any;

    logic             w_hit_eq;
    logic             w_full;
    logic             w_do_insert;
    logic             w_do_update;
    logic             w_do_erase;
    t_entry           w_rd;
    t_status          w_status;
    logic [POS_W-1:0] w_pos;
    t_entry           w_out_entry;
    logic [PW-1:0]    w_idx_wide;
    logic [CMP_W-1:0] w_count_wide;

    assign w_in_entry.key  = i_s_axis_tdata[63:0];
    assign w_in_entry.page = i_s_axis_tdata[95:64];
    assign w_in_entry.slot = i_s_axis_tdata[127:96];

    assign o_s_axis_tready = !r_busy;
    assign w_accept        = i_s_axis_tvalid && !r_busy;
    assign w_fire          = r_busy && (!r_out_valid || i_m_axis_tready);
    assign w_cmp_code      = order_code(w_in_entry.key, r_float);
    assign o_cfg_ready     = 1'b1;

    // Take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_RESET;
            r_float <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CAPACITY:  r_cap   <= i_cfg_data;
                CFG_KEY_FLOAT: r_float <= i_cfg_data[0];
                default:       ;
            endcase
        end
    end

    // Hold the request while it is in work
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
        end else if (w_fire) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= t_mode'(i_s_axis_tuser);
            r_req  <= w_in_entry;
            r_ri   <= i_s_axis_tdata[134:128];
        end
    end

    // Cells below the count are occupied; the first free cell takes new keys
    always_comb begin
        for (int j = 0; j < TABLE_DEPTH; j++) begin
            w_valid[j] = (CNT_W'(j) < r_count);
            w_top[j]   = (CNT_W'(j) == r_count);
        end
    end

    assign w_scan = (r_mode == MODE_ERASE) ? (w_eq & w_valid)
                                           : ((w_ge & w_valid) | w_top);

    sket_find #(
        .DEPTH (TABLE_DEPTH)
    ) u_find (
        .i_vec (w_scan),
        .o_hot (w_hot),
        .o_le  (w_le),
        .o_idx (w_idx),
        .o_any (w_any)
    );

    // Gather the entry at the read index
    always_comb begin
        w_rd = '0;
        for (int j = 0; j < TABLE_DEPTH; j++) begin
            if (RW'(r_ri) == RW'(j)) begin
                w_rd = w_rd | w_entry[j];
            end
        end
    end

    assign w_hit_eq     = |(w_hot & w_eq & w_valid);
    assign w_count_wide = CMP_W'(r_count);
    assign w_full       = (w_count_wide >= CMP_W'(r_cap))
                       || (w_count_wide >= CMP_W'(TABLE_DEPTH));
    assign w_idx_wide   = PW'(w_idx);

    // Decide the operation and its result
    always_comb begin
        w_do_insert = 1'b0;
        w_do_update = 1'b0;
        w_do_erase  = 1'b0;
        w_status    = ST_NOT_FOUND;
        w_pos       = '0;
        w_out_entry = '0;
        n_count     = r_count;
        case (r_mode)
            MODE_INSERT: begin
                if (w_any && w_hit_eq) begin
                    w_do_update = 1'b1;
                    w_status    = ST_UPDATED;
                    w_pos       = w_idx_wide[POS_W-1:0];
                end else if (w_full || !w_any) begin
                    w_status    = ST_FULL;
                end else begin
                    w_do_insert = 1'b1;
                    w_status    = ST_INSERTED;
                    w_pos       = w_idx_wide[POS_W-1:0];
                    n_count     = r_count + CNT_W'(1);
                end
            end
            MODE_ERASE: begin
                if (w_any) begin
                    w_do_erase = 1'b1;
                    w_status   = ST_ERASED;
                    w_pos      = w_idx_wide[POS_W-1:0];
                    n_count    = r_count - CNT_W'(1);
                end
            end
            MODE_READ: begin
                w_pos = r_ri;
                if (RW'(r_ri) < RW'(r_count)) begin
                    w_status    = ST_READ_OK;
                    w_out_entry = w_rd;
                end else begin
                    w_status = ST_RANGE;
                end
            end
            MODE_CLEAR: begin
                w_status = ST_CLEARED;
                n_count  = '0;
            end
            default: ;
        endcase
    end

    // Drive each cell's shift and load command
    always_comb begin
        for (int j = 0; j < TABLE_DEPTH; j++) begin
            w_ctl[j].shift_up   = w_fire && w_do_insert && !w_le[j];
            w_ctl[j].shift_down = w_fire && w_do_erase && (!w_le[j] || w_hot[j]);
            w_ctl[j].load_key   = w_fire && w_do_insert && w_hot[j];
            w_ctl[j].load_entry = w_fire && w_do_update && w_hot[j];
        end
    end

    // Cell chain
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        t_entry w_lo;
        t_entry w_hi;
        if (g == 0) begin : g_first
            assign w_lo = '0;
        end else begin : g_mid_lo
            assign w_lo = w_entry[g-1];
        end
        if (g == TABLE_DEPTH - 1) begin : g_last
            assign w_hi = '0;
        end else begin : g_mid_hi
            assign w_hi = w_entry[g+1];
        end
        sket_cell u_cell (
            .i_clk      (i_clk),
            .i_cmp_en   (w_accept),
            .i_is_float (r_float),
            .i_cmp_code (w_cmp_code),
            .i_ctl      (w_ctl[g]),
            .i_new      (r_req),
            .i_lo       (w_lo),
            .i_hi       (w_hi),
            .o_entry    (w_entry[g]),
            .o_ge       (w_ge[g]),
            .o_eq       (w_eq[g])
        );
    end

    // Advance the key count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_fire) begin
            r_count <= n_count;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_user <= w_status;
            r_out_data <= {1'b0, w_out_entry.slot, w_out_entry.page, w_out_entry.key,
                           w_pos, OCNT_W'(CMP_W'(n_count))};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= CMP_W'(TABLE_DEPTH))
        else $error("key count above table depth");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_status == ST_INSERTED) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the count by one");

    a_erase_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_status == ST_ERASED) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("erase did not shrink the count by one");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_busy))
        else $error("result appeared without a request in work");
`endif

endmodule
